@@ rtl/ptp_clock_servo_update_top_defines.svh @@
// ----------------------------------------------------------------------------
// ptp clock servo assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef PTP_CLOCK_SERVO_UPDATE_TOP_DEFINES_SVH
`define PTP_CLOCK_SERVO_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define PTPCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
// property checked during reset too
`define PTPCS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define PTPCS_ASSERT(lbl, prop)
`define PTPCS_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/ptpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptpcs_pkg
// shared types, codes and constants of the ptp clock servo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ptpcs_pkg;

  // register indexes
  localparam logic [2:0] REG_PROP_DIV  = 3'd0;
  localparam logic [2:0] REG_INTEG_DIV = 3'd1;
  localparam logic [2:0] REG_FSHIFT    = 3'd2;
  localparam logic [2:0] REG_ADJ_EN    = 3'd3;
  localparam logic [2:0] REG_MAX_FREQ  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_FREQ    = 2'd1;
  localparam logic [1:0] ST_STEP    = 2'd2;
  localparam logic [1:0] ST_NOADJ   = 2'd3;

  // step threshold: 20 ms in scaled nanoseconds
  localparam logic signed [63:0] STEP_THRESHOLD = 64'sd20000000 <<< 16;

  localparam int DIV_W  = 64;
  localparam int DVSR_W = 33;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_PREP, S_MUL, S_DIVF, S_WAITF, S_INTEG,
    S_DIVI, S_WAITI, S_DIVP, S_WAITP, S_DONE
  } state_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/ptpcs_div.sv @@
// ----------------------------------------------------------------------------
// ptpcs_div
// bit-serial restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ptp_clock_servo_update_top_defines.svh"
module ptpcs_div import ptpcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [5:0]        cnt;
  logic [DIV_W-1:0]  dq;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dv;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   shifted;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, dq[DIV_W-1]};
    trial   = shifted - {1'b0, dv};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      dv  <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DVSR_W]) begin
        rem <= trial[DVSR_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVSR_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

  `PTPCS_ASSERT(a_start_busy, req.start |=> busy)
  `PTPCS_ASSERT(a_done_after_busy, done |-> $past(busy))
  `PTPCS_ASSERT_RST(a_rst_idle, rst |=> !busy && !done)

endmodule

@@ rtl/ptp_clock_servo_update_top.sv @@
// ----------------------------------------------------------------------------
// ptp_clock_servo_update_top
// delay filter and pi frequency servo for ptp measurements
// ----------------------------------------------------------------------------
// Usage: one request on the input channel (in_valid / in_stall) carries a
// mean path delay and an offset from master. Exactly one result leaves on
// the output channel (out_valid / out_stall) for every request.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// An ignored request goes straight to the result. Otherwise the filter runs
// a shift search, a set-up step, a shift-add multiply and a serial division;
// a time step then ends there. The controller adds an integrator step and
// two more divisions, all on the shared bit-serial divider.
// One request is processed at a time; the next is taken once the result has
// been loaded into the output register, even while it waits.
// Reset clears integrator and filter state and sets configuration registers to their defaults.
// A stalled result holds in the output register; the block then finishes
// the next request and waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ptp_clock_servo_update_top_defines.svh"
module ptp_clock_servo_update_top import ptpcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               delay_seconds_nonzero,
  input  logic signed [47:0] mean_delay,
  input  logic               offset_seconds_nonzero,
  input  logic signed [47:0] offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] freq_adjust,
  output logic [47:0]        filtered_delay,
  output logic signed [63:0] drift,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  // configuration
  logic [19:0] prop_div, integ_div, max_freq;
  logic [4:0]  fshift;
  logic        adj_en;

  // servo state
  logic signed [63:0] integ;
  logic [63:0]        avg;
  logic [32:0]        flen;

  // working registers
  state_t             state, state_next;
  logic signed [63:0] dly, ofs;
  logic               osec;
  logic [4:0]         s;
  logic [63:0]        acc, mc;
  logic [32:0]        mr;
  logic signed [63:0] lim, iterm;
  logic               neg;
  logic [1:0]         r_status;
  logic signed [31:0] r_freq;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_acc, out_free, step_req;
  logic [32:0] pow_s, len_clip;
  logic [63:0] triple, sel_val;
  logic signed [63:0] isum, qs, adj;
  logic [19:0] idv, pdv;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign idv      = (integ_div == '0) ? 20'd1 : integ_div;
  assign pdv      = (prop_div == '0) ? 20'd1 : prop_div;

  // shared divider
  ptpcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // filter and controller arithmetic
  always_comb begin
    pow_s    = 33'd1 << s;
    len_clip = (flen > pow_s) ? pow_s : flen;
    if (len_clip < pow_s) len_clip = len_clip + 33'd1;
    triple   = avg + (avg << 1);
    sel_val  = dly[63] ? avg : dly;
    if (sel_val > triple) sel_val = (avg << 1) + 64'(flen) + 64'd1;
    step_req = adj_en && (osec || ofs > STEP_THRESHOLD || ofs < -STEP_THRESHOLD);
    isum     = integ + ofs;
    if (isum > lim) isum = lim;
    else if (isum < -lim) isum = -lim;
    qs       = neg ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
    adj      = qs + iterm;
  end

  // divider request
  always_comb begin
    div_req = '0;
    unique case (state)
      S_DIVF: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc;
        div_req.divisor  = flen;
      end
      S_DIVI: begin
        div_req.start    = 1'b1;
        div_req.dividend = (integ <= 0) ? 64'(-integ) : 64'(integ);
        div_req.divisor  = 33'(idv);
      end
      S_DIVP: begin
        div_req.start    = 1'b1;
        div_req.dividend = (ofs <= 0) ? 64'(-ofs) : 64'(ofs);
        div_req.divisor  = 33'(pdv);
      end
      default: div_req = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc) state_next = delay_seconds_nonzero ? S_DONE : S_SEARCH;
      S_SEARCH: if (!(s != 5'd0 && (avg >> (6'd63 - 6'(s))) != 64'd0)) state_next = S_PREP;
      S_PREP:   state_next = S_MUL;
      S_MUL:    if (mr == '0) state_next = S_DIVF;
      S_DIVF:   state_next = S_WAITF;
      S_WAITF:  if (div_rsp.done) state_next = step_req ? S_DONE : S_INTEG;
      S_INTEG:  state_next = S_DIVI;
      S_DIVI:   state_next = S_WAITI;
      S_WAITI:  if (div_rsp.done) state_next = S_DIVP;
      S_DIVP:   state_next = S_WAITP;
      S_WAITP:  if (div_rsp.done) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_div  <= 20'd10;
      integ_div <= 20'd1000;
      fshift    <= 5'd14;
      adj_en    <= 1'b1;
      max_freq  <= 20'd512000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_DIV:  prop_div  <= cfg_data;
        REG_INTEG_DIV: integ_div <= cfg_data;
        REG_FSHIFT:    fshift    <= cfg_data[4:0];
        REG_ADJ_EN:    adj_en    <= cfg_data[0];
        REG_MAX_FREQ:  max_freq  <= cfg_data;
        default: ;
      endcase
    end
  end

  // servo state and sequencing datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      avg   <= '0;
      flen  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && !delay_seconds_nonzero) begin
            if (flen == '0) avg <= mean_delay[47] ? 64'd0 : 64'(mean_delay);
          end
        end
        S_SEARCH: begin
          if (state_next == S_PREP) flen <= len_clip;
        end
        S_WAITF: begin
          if (div_rsp.done) begin
            avg <= div_rsp.quotient;
            if (step_req) begin
              integ <= '0;
              flen  <= '0;
            end
          end
        end
        S_INTEG: integ <= isum;
        default: ;
      endcase
    end
  end

  // payload working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dly  <= 64'(mean_delay);
        ofs  <= 64'(offset);
        osec <= offset_seconds_nonzero;
        s    <= fshift;
        r_status <= ST_IGNORED;
        r_freq   <= '0;
      end
      S_SEARCH: if (state_next == S_SEARCH) s <= s - 5'd1;
      S_PREP: begin
        acc <= sel_val;
        mc  <= avg;
        mr  <= flen - 33'd1;
        lim <= $signed(64'(40'(max_freq) * 40'(integ_div)) << 16);
      end
      S_MUL: begin
        if (mr[0]) acc <= acc + mc;
        mc <= mc << 1;
        mr <= mr >> 1;
      end
      S_WAITF: if (div_rsp.done && step_req) r_status <= ST_STEP;
      S_DIVI:  neg <= (integ <= 0);
      S_WAITI: if (div_rsp.done) iterm <= qs;
      S_DIVP:  neg <= (ofs <= 0);
      S_WAITP: begin
        if (div_rsp.done) begin
          r_status <= adj_en ? ST_FREQ : ST_NOADJ;
          r_freq   <= adj_en ? adj[47:16] : 32'sd0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status         <= r_status;
      freq_adjust    <= r_freq;
      filtered_delay <= avg[47:0];
      drift          <= integ;
    end
  end

  `PTPCS_ASSERT(a_accept_busy, in_acc |=> state != S_IDLE)
  `PTPCS_ASSERT(a_done_waiting,
    div_rsp.done |-> (state == S_WAITF || state == S_WAITI || state == S_WAITP))
  `PTPCS_ASSERT(a_result_loaded, (state == S_DONE && out_free) |=> out_valid)
  `PTPCS_ASSERT(a_no_start_busy, div_req.start |-> !div_rsp.busy)

endmodule
